>>> rtl/i2c_eeprom_random_read_master_defines.svh
// Assertion macros shared by the I2C EEPROM read master RTL.
// Uses the clk and rst_n names of the module that includes it.
`ifndef I2C_EEPROM_RANDOM_READ_MASTER_DEFINES_SVH
`define I2C_EEPROM_RANDOM_READ_MASTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/i2cee_pkg.sv
// Package for the I2C EEPROM random read master: phase codes, state and
// result structs, and shared constants. Depends on nothing.
package i2cee_pkg;

  localparam logic [6:0] DEV_ADDR_RESET    = 7'd87;
  localparam int         MAX_BYTES_DEFAULT = 256;

  // Number of data bits in one byte; the ninth slot of a byte is the ack bit.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START   = 5'd1,
    PH_DEVW    = 5'd2,
    PH_AHI     = 5'd3,
    PH_ALO     = 5'd4,
    PH_RESTART = 5'd5,
    PH_DEVR    = 5'd6,
    PH_RX      = 5'd7,
    PH_STOP    = 5'd8
  } phase_t;

  // Bus sequencer state, apart from the byte counter whose width is set by
  // a parameter.
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  quarter;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] target;
    logic        error;
    logic        scl;
    logic        sda;
  } ctrl_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       done_res;
    logic       addr_nack;
    logic       busy_res;
  } result_t;

endpackage

>>> rtl/i2cee_if.sv
// Valid/ready channel interfaces of the I2C EEPROM random read master:
// command input, bus-slot result output and device address write.
interface i2cee_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] mem_address;
  logic [8:0]  byte_count;
  logic        sda_in;

  modport source (output valid, command, mem_address, byte_count, sda_in, input ready);
  modport sink   (input valid, command, mem_address, byte_count, sda_in, output ready);
endinterface

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       byte_valid;
  logic [7:0] read_byte;
  logic       last_byte;
  logic       done_res;
  logic       addr_nack;
  logic       busy_res;

  modport source (output valid, scl_release, sda_release, byte_valid, read_byte,
                  last_byte, done_res, addr_nack, busy_res, input ready);
  modport sink   (input valid, scl_release, sda_release, byte_valid, read_byte,
                  last_byte, done_res, addr_nack, busy_res, output ready);
endinterface

interface i2cee_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] slave_addr;

  modport source (output valid, slave_addr, input ready);
  modport sink   (input valid, slave_addr, output ready);
endinterface

>>> rtl/i2c_eeprom_random_read_master.sv
// Top level of the I2C EEPROM random sequential read master.
// Depends on i2cee_pkg, the channel interfaces in i2cee_if.sv, i2cee_step
// and the assertion macros in i2c_eeprom_random_read_master_defines.svh.
//
// Usage: the in_ch channel carries one item per quarter-bit bus slot. An
// item with command set to start, sent while the master is idle, loads the
// 16-bit memory address and the byte count; every tick item then moves the
// bus by one quarter bit. Each accepted item yields exactly one item on
// out_ch, holding the SCL and SDA release levels for that slot, a received
// byte with its last flag, the done pulse, the address NACK flag and busy.
// The result of an item is in the output register on the cycle after it is
// accepted. Throughput is one item per cycle while out_ch does not stall; the
// sequencer state and the output register are written in the same cycle,
// so the loop through the step logic sets that figure.
// When out_ch stalls, the output register holds its item and in_ch.ready
// drops until the item is taken; in_ch.ready is high again in the same
// cycle that out_ch accepts, so no bubble is added.
// cfg_ch writes the seven-bit device address and is always ready; write it
// only while the master is idle.
// Reset (rst_n low, synchronous) returns the master to idle with both lines
// released, empties the output register and sets the device address to 87.

`include "i2c_eeprom_random_read_master_defines.svh"

module i2c_eeprom_random_read_master #(
  parameter int MAX_BYTES = i2cee_pkg::MAX_BYTES_DEFAULT
) (
  input logic         clk,
  input logic         rst_n,
  i2cee_in_if.sink    in_ch,
  i2cee_out_if.source out_ch,
  i2cee_cfg_if.sink   cfg_ch
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  // Sequencer state.
  i2cee_pkg::ctrl_t   ctrl_r;
  i2cee_pkg::ctrl_t   ctrl_nxt;
  logic [CNT_W-1:0]   left_r;
  logic [CNT_W-1:0]   left_nxt;
  logic [6:0]         dev_addr_r;

  // Output register.
  logic               out_valid_r;
  i2cee_pkg::result_t res_r;
  i2cee_pkg::result_t res_nxt;

  logic               in_fire;

  // The output register frees up in the cycle its item is taken.
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  i2cee_step #(
    .MAX_BYTES (MAX_BYTES)
  ) u_step (
    .ctrl_cur       (ctrl_r),
    .left_cur       (left_r),
    .command        (in_ch.command),
    .mem_address    (in_ch.mem_address),
    .byte_count     (in_ch.byte_count),
    .sda_in         (in_ch.sda_in),
    .slave_addr     (dev_addr_r),
    .ctrl_nxt       (ctrl_nxt),
    .left_nxt       (left_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase   <= i2cee_pkg::PH_IDLE;
      ctrl_r.quarter <= 2'd0;
      ctrl_r.bit_cnt <= 4'd0;
      ctrl_r.shreg   <= 8'd0;
      ctrl_r.target  <= 16'd0;
      ctrl_r.error   <= 1'b0;
      ctrl_r.scl     <= 1'b1;
      ctrl_r.sda     <= 1'b1;
      left_r         <= '0;
    end else if (in_fire) begin
      ctrl_r <= ctrl_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cee_pkg::DEV_ADDR_RESET;
    end else if (cfg_ch.valid) begin
      dev_addr_r <= cfg_ch.slave_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_release = res_r.scl_release;
  assign out_ch.sda_release = res_r.sda_release;
  assign out_ch.byte_valid  = res_r.byte_valid;
  assign out_ch.read_byte   = res_r.read_byte;
  assign out_ch.last_byte   = res_r.last_byte;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.addr_nack   = res_r.addr_nack;
  assign out_ch.busy_res    = res_r.busy_res;

  // The slot counter only runs while a transaction is open.
  `I2CEE_ASSERT_NOW(a_idle_slot_zero, ctrl_r.phase == i2cee_pkg::PH_IDLE,
    ctrl_r.quarter == 2'd0, "slot counter not zero while idle")

  // The bit counter never passes the ack slot.
  `I2CEE_ASSERT_NOW(a_bit_cnt_range, 1'b1,
    ctrl_r.bit_cnt <= i2cee_pkg::BITS_PER_BYTE, "bit counter out of range")

  // A start command during a transaction leaves the sequencer where it was.
  `I2CEE_ASSERT_NEXT(a_start_busy_ignored,
    in_fire && in_ch.command == i2cee_pkg::CMD_START &&
    ctrl_r.phase != i2cee_pkg::PH_IDLE,
    ctrl_r == $past(ctrl_r) && left_r == $past(left_r),
    "start while busy changed the sequencer state")

  // A received byte is only presented inside a running transaction.
  `I2CEE_ASSERT_NOW(a_byte_while_busy, out_valid_r && res_r.byte_valid,
    res_r.busy_res && !res_r.done_res, "byte presented outside a transaction")

  // While receiving, there is always at least one byte still owed.
  `I2CEE_ASSERT_NOW(a_rx_left_nonzero, ctrl_r.phase == i2cee_pkg::PH_RX,
    left_r != '0, "receive phase with no bytes left")

endmodule

>>> rtl/i2cee_step.sv
// One quarter-bit step of the I2C read sequencer: next state and result
// from the current state and one item. Depends on i2cee_pkg.
module i2cee_step #(
  parameter int MAX_BYTES = i2cee_pkg::MAX_BYTES_DEFAULT
) (
  input  i2cee_pkg::ctrl_t                  ctrl_cur,
  input  logic [$clog2(MAX_BYTES+1)-1:0]    left_cur,
  input  logic                              command,
  input  logic [15:0]                       mem_address,
  input  logic [8:0]                        byte_count,
  input  logic                              sda_in,
  input  logic [6:0]                        slave_addr,
  output i2cee_pkg::ctrl_t                  ctrl_nxt,
  output logic [$clog2(MAX_BYTES+1)-1:0]    left_nxt,
  output i2cee_pkg::result_t                res
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  logic             last_q;
  logic             use_slot;
  logic             slot_v;
  logic             left_le1;
  logic             valid;
  logic             done;
  logic [7:0]       rbyte;
  logic             lastb;
  logic [8:0]       cnt;
  i2cee_pkg::ctrl_t n;
  logic [CNT_W-1:0] left_n;

  assign last_q   = (ctrl_cur.quarter == 2'd3);
  assign left_le1 = (left_cur <= CNT_W'(1));

  always_comb begin
    n        = ctrl_cur;
    left_n   = left_cur;
    use_slot = 1'b0;
    slot_v   = 1'b1;
    valid    = 1'b0;
    done     = 1'b0;
    rbyte    = 8'd0;
    lastb    = 1'b0;
    cnt      = (byte_count == 9'd0) ? 9'd1 : byte_count;

    if (command == i2cee_pkg::CMD_START) begin
      // A start while a transaction runs is dropped.
      if (ctrl_cur.phase == i2cee_pkg::PH_IDLE) begin
        if (32'(cnt) > 32'(MAX_BYTES)) begin
          left_n = CNT_W'(MAX_BYTES);
        end else begin
          left_n = CNT_W'(cnt);
        end
        n.target  = mem_address;
        n.error   = 1'b0;
        n.bit_cnt = 4'd0;
        n.shreg   = 8'd0;
        n.quarter = 2'd0;
        n.phase   = i2cee_pkg::PH_START;
      end
    end else begin
      case (ctrl_cur.phase)
        i2cee_pkg::PH_IDLE: begin
          n.scl = 1'b1;
          n.sda = 1'b1;
        end
        i2cee_pkg::PH_START: begin
          n.scl = 1'b1;
          n.sda = ~ctrl_cur.quarter[1];
          if (last_q) begin
            n.phase   = i2cee_pkg::PH_DEVW;
            n.shreg   = {slave_addr, 1'b0};
            n.bit_cnt = 4'd0;
          end
        end
        i2cee_pkg::PH_DEVW, i2cee_pkg::PH_AHI, i2cee_pkg::PH_ALO,
        i2cee_pkg::PH_DEVR: begin
          use_slot = 1'b1;
          if (ctrl_cur.bit_cnt < i2cee_pkg::BITS_PER_BYTE) begin
            slot_v = ctrl_cur.shreg[7];
            if (last_q) begin
              n.shreg   = {ctrl_cur.shreg[6:0], 1'b0};
              n.bit_cnt = ctrl_cur.bit_cnt + 4'd1;
            end
          end else begin
            // Ack slot: release SDA and look for the slave's ack.
            slot_v = 1'b1;
            if (ctrl_cur.quarter == 2'd2 && sda_in) begin
              n.error = 1'b1;
            end
            if (last_q) begin
              n.bit_cnt = 4'd0;
              if (n.error) begin
                n.phase = i2cee_pkg::PH_STOP;
              end else if (ctrl_cur.phase == i2cee_pkg::PH_DEVW) begin
                n.phase = i2cee_pkg::PH_AHI;
                n.shreg = ctrl_cur.target[15:8];
              end else if (ctrl_cur.phase == i2cee_pkg::PH_AHI) begin
                n.phase = i2cee_pkg::PH_ALO;
                n.shreg = ctrl_cur.target[7:0];
              end else if (ctrl_cur.phase == i2cee_pkg::PH_ALO) begin
                n.phase = i2cee_pkg::PH_RESTART;
              end else begin
                n.phase = i2cee_pkg::PH_RX;
                n.shreg = 8'd0;
              end
            end
          end
        end
        i2cee_pkg::PH_RESTART: begin
          case (ctrl_cur.quarter)
            2'd0:    begin n.scl = 1'b0; end
            2'd1:    begin n.scl = 1'b0; n.sda = 1'b1; end
            2'd2:    begin n.scl = 1'b1; n.sda = 1'b1; end
            default: begin n.scl = 1'b1; n.sda = 1'b0; end
          endcase
          if (last_q) begin
            n.phase   = i2cee_pkg::PH_DEVR;
            n.shreg   = {slave_addr, 1'b1};
            n.bit_cnt = 4'd0;
          end
        end
        i2cee_pkg::PH_RX: begin
          use_slot = 1'b1;
          if (ctrl_cur.bit_cnt < i2cee_pkg::BITS_PER_BYTE) begin
            slot_v = 1'b1;
            if (ctrl_cur.quarter == 2'd2) begin
              n.shreg = {ctrl_cur.shreg[6:0], sda_in};
            end
            if (last_q) begin
              n.bit_cnt = ctrl_cur.bit_cnt + 4'd1;
              if (n.bit_cnt == i2cee_pkg::BITS_PER_BYTE) begin
                valid = 1'b1;
                rbyte = ctrl_cur.shreg;
                lastb = left_le1;
              end
            end
          end else begin
            // Master ack for all but the last byte, NACK after it.
            slot_v = left_le1;
            if (last_q) begin
              n.bit_cnt = 4'd0;
              n.shreg   = 8'd0;
              if (left_le1) begin
                left_n  = '0;
                n.phase = i2cee_pkg::PH_STOP;
              end else begin
                left_n = left_cur - CNT_W'(1);
              end
            end
          end
        end
        i2cee_pkg::PH_STOP: begin
          case (ctrl_cur.quarter)
            2'd0:    begin n.scl = 1'b0; end
            2'd1:    begin n.scl = 1'b0; n.sda = 1'b0; end
            2'd2:    begin n.scl = 1'b1; n.sda = 1'b0; end
            default: begin n.scl = 1'b1; n.sda = 1'b1; end
          endcase
          if (last_q) begin
            done    = 1'b1;
            n.phase = i2cee_pkg::PH_IDLE;
          end
        end
        default: begin
          n.phase = i2cee_pkg::PH_IDLE;
          n.scl   = 1'b1;
          n.sda   = 1'b1;
        end
      endcase

      if (use_slot) begin
        n.scl = ctrl_cur.quarter[1];
        if (ctrl_cur.quarter != 2'd0) begin
          n.sda = slot_v;
        end
      end

      if (n.phase == i2cee_pkg::PH_IDLE) begin
        n.quarter = 2'd0;
      end else begin
        n.quarter = ctrl_cur.quarter + 2'd1;
      end
    end
  end

  assign ctrl_nxt = n;
  assign left_nxt = left_n;

  assign res.scl_release = n.scl;
  assign res.sda_release = n.sda;
  assign res.byte_valid  = valid;
  assign res.read_byte   = rbyte;
  assign res.last_byte   = lastb;
  assign res.done_res    = done;
  assign res.addr_nack   = n.error;
  assign res.busy_res    = (n.phase != i2cee_pkg::PH_IDLE);

endmodule

>>> dv/i2c_eeprom_random_read_master_tb.sv
// Self-checking testbench for the I2C EEPROM random read master: drives start and tick
// items, predicts every bus slot result in-line and compares it field by field.
// Depends on i2cee_pkg, the channel interfaces in i2cee_if.sv and the RTL top level.
module i2c_eeprom_random_read_master_tb;

  // The block is built with its default byte limit, so the predictor uses the same one.
  localparam int MAX_BYTES = i2cee_pkg::MAX_BYTES_DEFAULT;

  // The receiver is held off once for a long stretch while the sender keeps offering items.
  localparam int SQUEEZE_AT  = 40;
  localparam int SQUEEZE_LEN = 120;

  // The idle pattern moves through its four modes in turn so gaps land on every part of a transfer.
  localparam int GAP_SPAN = 200;

  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 3000;

  typedef enum int {
    GAP_NONE,
    GAP_SENDER,
    GAP_RECEIVER,
    GAP_BOTH
  } gap_mode_t;

  // One input item as the channel carries it.
  typedef struct packed {
    logic        command;
    logic [15:0] mem_address;
    logic [8:0]  byte_count;
    logic        sda_in;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cee_in_if  in_ch ();
  i2cee_out_if out_ch ();
  i2cee_cfg_if cfg_ch ();

  i2c_eeprom_random_read_master u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Items waiting to be offered, and the slot results predicted for accepted items.
  bus_item_t          pending_items[$];
  i2cee_pkg::result_t predicted_slots[$];
  bus_item_t          cur_item;
  int                 errors;

  int cyc;
  int hold_left;
  int quiet;

  // Predictor copy of the master: the sequencer state, the bus lines and the device address.
  i2cee_pkg::phase_t ph        = i2cee_pkg::PH_IDLE;
  logic [1:0]        qslot     = 2'd0;
  logic [3:0]        bitn      = 4'd0;
  logic [7:0]        shifter   = 8'd0;
  logic [15:0]       target    = 16'd0;
  logic [8:0]        remaining = 9'd0;
  logic              nacked    = 1'b0;
  logic              scl_lvl   = 1'b1;
  logic              sda_lvl   = 1'b1;
  logic [6:0]        dev_addr  = i2cee_pkg::DEV_ADDR_RESET;

  // A normal bit slot: SCL low in the first half, released in the second half.
  // SDA keeps its level in slot 0 and takes the new bit from slot 1 on.
  function automatic void drive_bit(logic v);
    if (qslot != 2'd0) sda_lvl = v;
    scl_lvl = qslot[1];
  endfunction

  // Advances the predicted master by one accepted item and returns its slot result.
  function automatic i2cee_pkg::result_t advance_master(bus_item_t it);
    i2cee_pkg::result_t r;
    logic               at_end;
    logic               finished;
    logic [8:0]         n;
    r        = '0;
    at_end   = (qslot == 2'd3);
    finished = 1'b0;
    if (it.command == i2cee_pkg::CMD_START) begin
      // A start is only taken while idle; while busy it is dropped and the lines repeat.
      if (ph == i2cee_pkg::PH_IDLE) begin
        n = it.byte_count;
        if (n == 9'd0) n = 9'd1;
        if (int'(n) > MAX_BYTES) n = 9'(MAX_BYTES);
        remaining = n;
        target    = it.mem_address;
        nacked    = 1'b0;
        bitn      = 4'd0;
        shifter   = 8'd0;
        qslot     = 2'd0;
        ph        = i2cee_pkg::PH_START;
      end
    end else begin
      case (ph)
        i2cee_pkg::PH_IDLE: begin
          scl_lvl = 1'b1;
          sda_lvl = 1'b1;
        end
        i2cee_pkg::PH_START: begin
          scl_lvl = 1'b1;
          sda_lvl = (qslot < 2'd2);
          if (at_end) begin
            ph      = i2cee_pkg::PH_DEVW;
            shifter = {dev_addr, 1'b0};
            bitn    = 4'd0;
          end
        end
        i2cee_pkg::PH_DEVW, i2cee_pkg::PH_AHI, i2cee_pkg::PH_ALO,
        i2cee_pkg::PH_DEVR: begin
          if (bitn < i2cee_pkg::BITS_PER_BYTE) begin
            drive_bit(shifter[7]);
            if (at_end) begin
              shifter = shifter << 1;
              bitn    = bitn + 4'd1;
            end
          end else begin
            // Ack bit: SDA released, slave must pull it low by the sampling slot.
            drive_bit(1'b1);
            if (qslot == 2'd2 && it.sda_in) nacked = 1'b1;
            if (at_end) begin
              bitn = 4'd0;
              if (nacked) begin
                ph = i2cee_pkg::PH_STOP;
              end else begin
                case (ph)
                  i2cee_pkg::PH_DEVW: begin
                    ph      = i2cee_pkg::PH_AHI;
                    shifter = target[15:8];
                  end
                  i2cee_pkg::PH_AHI: begin
                    ph      = i2cee_pkg::PH_ALO;
                    shifter = target[7:0];
                  end
                  i2cee_pkg::PH_ALO: ph = i2cee_pkg::PH_RESTART;
                  default: begin
                    ph      = i2cee_pkg::PH_RX;
                    shifter = 8'd0;
                  end
                endcase
              end
            end
          end
        end
        i2cee_pkg::PH_RESTART: begin
          case (qslot)
            2'd0: scl_lvl = 1'b0;
            2'd1: begin
              scl_lvl = 1'b0;
              sda_lvl = 1'b1;
            end
            2'd2: begin
              scl_lvl = 1'b1;
              sda_lvl = 1'b1;
            end
            default: begin
              scl_lvl = 1'b1;
              sda_lvl = 1'b0;
            end
          endcase
          if (at_end) begin
            ph      = i2cee_pkg::PH_DEVR;
            shifter = {dev_addr, 1'b1};
            bitn    = 4'd0;
          end
        end
        i2cee_pkg::PH_RX: begin
          if (bitn < i2cee_pkg::BITS_PER_BYTE) begin
            drive_bit(1'b1);
            if (qslot == 2'd2) shifter = {shifter[6:0], it.sda_in};
            if (at_end) begin
              bitn = bitn + 4'd1;
              // The byte is presented in the last slot of its eighth bit.
              if (bitn == i2cee_pkg::BITS_PER_BYTE) begin
                r.byte_valid = 1'b1;
                r.read_byte  = shifter;
                r.last_byte  = (remaining <= 9'd1);
              end
            end
          end else begin
            // Master ack on all bytes but the last, NACK on the last one.
            drive_bit(remaining <= 9'd1);
            if (at_end) begin
              bitn    = 4'd0;
              shifter = 8'd0;
              if (remaining <= 9'd1) begin
                remaining = 9'd0;
                ph        = i2cee_pkg::PH_STOP;
              end else begin
                remaining = remaining - 9'd1;
              end
            end
          end
        end
        i2cee_pkg::PH_STOP: begin
          case (qslot)
            2'd0: scl_lvl = 1'b0;
            2'd1: begin
              scl_lvl = 1'b0;
              sda_lvl = 1'b0;
            end
            2'd2: begin
              scl_lvl = 1'b1;
              sda_lvl = 1'b0;
            end
            default: begin
              scl_lvl = 1'b1;
              sda_lvl = 1'b1;
            end
          endcase
          if (at_end) begin
            finished = 1'b1;
            ph       = i2cee_pkg::PH_IDLE;
          end
        end
        default: begin
          ph      = i2cee_pkg::PH_IDLE;
          scl_lvl = 1'b1;
          sda_lvl = 1'b1;
        end
      endcase
      if (ph == i2cee_pkg::PH_IDLE) qslot = 2'd0;
      else if (!finished) qslot = qslot + 2'd1;
    end
    r.scl_release = scl_lvl;
    r.sda_release = sda_lvl;
    r.done_res    = finished;
    r.addr_nack   = nacked;
    r.busy_res    = (ph != i2cee_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic gap_mode_t gap_mode();
    return gap_mode_t'((cyc / GAP_SPAN) % 4);
  endfunction

  function automatic logic sender_rests();
    int roll;
    roll = $urandom_range(99);
    return (gap_mode() == GAP_SENDER && roll < 87) || (gap_mode() == GAP_BOTH && roll < 14);
  endfunction

  function automatic logic receiver_stalls();
    int roll;
    roll = $urandom_range(99);
    return (gap_mode() == GAP_RECEIVER && roll < 87) || (gap_mode() == GAP_BOTH && roll < 14);
  endfunction

  // Tick items carry junk in the address and count fields; the block must ignore them.
  task automatic push_tick(input logic sda);
    bus_item_t it;
    it.command     = i2cee_pkg::CMD_TICK;
    it.mem_address = 16'($urandom);
    it.byte_count  = 9'($urandom);
    it.sda_in      = sda;
    pending_items.push_back(it);
  endtask

  task automatic push_start(input logic [15:0] addr, input logic [8:0] count);
    bus_item_t it;
    it.command     = i2cee_pkg::CMD_START;
    it.mem_address = addr;
    it.byte_count  = count;
    it.sda_in      = 1'($urandom_range(1));
    pending_items.push_back(it);
  endtask

  // Queues one whole read: the start item and every tick up to the end of STOP.
  // The slave acks every address phase except the one given by nack_at (-1 for none).
  // SDA is random everywhere else, which also gives the data bits. Starts sent
  // while busy are scattered in at busy_pct percent; they must not move the timing.
  task automatic queue_read(input logic [15:0] addr, input logic [8:0] count,
                            input int nack_at, input int busy_pct);
    int   nbytes;
    int   total;
    int   ack_tick;
    logic sda;
    nbytes = (count == 9'd0) ? 1 : ((int'(count) > MAX_BYTES) ? MAX_BYTES : int'(count));
    // START plus three address bytes and the repeated START make 116 ticks, the read
    // address 36 more, each data byte 36 and STOP 4. A NACK cuts straight to STOP.
    if (nack_at < 0) total = 156 + 36 * nbytes;
    else total = 40 + 36 * nack_at + ((nack_at == 3) ? 4 : 0) + 4;
    push_start(addr, count);
    for (int t = 0; t < total; t++) begin
      if ($urandom_range(99) < busy_pct) push_start(16'($urandom), 9'($urandom));
      sda = 1'($urandom_range(1));
      for (int j = 0; j < 4; j++) begin
        ack_tick = 38 + 36 * j + ((j == 3) ? 4 : 0);
        if (t == ack_tick) sda = (j == nack_at);
      end
      push_tick(sda);
    end
  endtask

  // Waits until every queued item is taken and every predicted result has come back,
  // then lets the registered output stage settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || predicted_slots.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_device_address(input logic [6:0] value);
    @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.slave_addr <= value;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    dev_addr = value;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Driver: offers items from the pending queue and feeds every accepted item to the
  // predictor at the edge where it is accepted. Valid is assigned once per edge.
  always @(posedge clk) begin
    logic took;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) predicted_slots.push_back(advance_master(cur_item));
      if (!in_ch.valid || took) begin
        if (pending_items.size() != 0 && !sender_rests()) begin
          cur_item = pending_items.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.command     <= cur_item.command;
          in_ch.mem_address <= cur_item.mem_address;
          in_ch.byte_count  <= cur_item.byte_count;
          in_ch.sda_in      <= cur_item.sda_in;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    i2cee_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_slots.size() == 0) begin
          $error("result item arrived with no prediction waiting");
          errors++;
        end else begin
          want = predicted_slots.pop_front();
          check_field("scl_release", 32'(want.scl_release), 32'(out_ch.scl_release));
          check_field("sda_release", 32'(want.sda_release), 32'(out_ch.sda_release));
          check_field("byte_valid",  32'(want.byte_valid),  32'(out_ch.byte_valid));
          check_field("read_byte",   32'(want.read_byte),   32'(out_ch.read_byte));
          check_field("last_byte",   32'(want.last_byte),   32'(out_ch.last_byte));
          check_field("done_res",    32'(want.done_res),    32'(out_ch.done_res));
          check_field("addr_nack",   32'(want.addr_nack),   32'(out_ch.addr_nack));
          check_field("busy_res",    32'(want.busy_res),    32'(out_ch.busy_res));
        end
      end
      out_ch.ready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  // Cycle count for the idle pattern, and the one long receiver hold-off. The hold
  // falls in the first no-idle window, so the sender keeps pushing and the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      cyc       <= 0;
      hold_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc == SQUEEZE_AT) hold_left <= SQUEEZE_LEN;
      else if (hold_left != 0) hold_left <= hold_left - 1;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("i2c_eeprom_random_read_master_tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [6:0] settings[2];
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = i2cee_pkg::CMD_TICK;
    in_ch.mem_address = 16'd0;
    in_ch.byte_count  = 9'd0;
    in_ch.sda_in      = 1'b1;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.slave_addr = 7'd0;
    errors            = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed reads under the reset device address: ticks while idle, a zero count
    // with busy starts scattered in, and a NACK right after the write address.
    push_tick(1'b0);
    push_tick(1'b1);
    queue_read(16'hFFFF, 9'd0, -1, 10);
    queue_read(16'h00FF, 9'd3, 0, 0);
    drain();

    // The device address extremes: a NACK after the low address byte under one, and
    // under the other a NACK on the read address and then a clean two-byte read.
    // The address is only changed once the previous batch has fully completed.
    settings[0] = 7'd0;
    settings[1] = 7'd127;
    foreach (settings[s]) begin
      set_device_address(settings[s]);
      @(negedge clk);
      if (s == 0) begin
        queue_read(16'h8001, 9'd2, 2, 0);
      end else begin
        queue_read(16'h7FFE, 9'd2, 3, 0);
        queue_read(16'hA5C3, 9'd2, -1, 3);
      end
      drain();
    end

    if (errors == 0) begin
      $display("i2c_eeprom_random_read_master_tb: done, clean");
    end else begin
      $display("i2c_eeprom_random_read_master_tb: done, errors");
    end
    $finish;
  end

endmodule
